// ===== hdl/udip_pkg.sv =====
package udip_pkg;

	localparam int EXP_LIMIT_DEF = 40;
	localparam int EXP_W = 7;
	localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	// largest value that can still be multiplied by ten without passing the maximum
	localparam logic [63:0] MUL_GUARD = 64'h0CCC_CCCC_CCCC_CCCC;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [20:0] CP_LOW_E = 21'h65;
	localparam logic [20:0] CP_UP_E  = 21'h45;

	typedef enum logic [4:0] {
		PH_PREFIX  = 5'b00001,
		PH_DIGITS  = 5'b00010,
		PH_EPREFIX = 5'b00100,
		PH_EDIGITS = 5'b01000,
		PH_DONE    = 5'b10000
	} phase_t;

	// packet handed from the scanner to the scaler
	typedef struct packed {
		logic             negative;
		logic [63:0]      mantissa;
		logic [EXP_W-1:0] exp_mag;
		logic             exp_neg;
	} job_t;

	typedef logic [20:0] zero_tab_t [21];
	typedef logic [20:0] one_tab_t [19];

	localparam zero_tab_t ZERO_POINTS = '{
		21'h1D7F6, 21'h1D7EC, 21'h1D7E2, 21'h1D7D8, 21'h1D7CE, 21'h11066, 21'h1810,
		21'h17E0, 21'h1040, 21'h0F20, 21'h0ED0, 21'h0E50, 21'h0CE6, 21'h0C66,
		21'h0BE7, 21'h0B66, 21'h0AE6, 21'h09E6, 21'h0966, 21'h06F0, 21'h0660
	};

	localparam one_tab_t ONE_POINTS = '{
		21'h278A, 21'h2780, 21'h2776, 21'h2488, 21'h2474, 21'h2460, 21'h11052,
		21'h10107, 21'h102EA, 21'h10858, 21'h10916, 21'h10320, 21'h1D360, 21'h102E1,
		21'h3021, 21'h2170, 21'h2160, 21'h1372, 21'h2469
	};

	// digit value in [3:0], valid in [4]
	function automatic logic [4:0] digit_of(input logic [20:0] cp);
		logic [4:0]  r;
		logic [15:0] d;
		r = 5'd0;
		if (cp >= 21'h30 && cp <= 21'h39) begin
			r = {1'b1, cp[3:0]};
		end else begin
			for (int i = 20; i >= 0; i--) begin
				d = cp[15:0] - ZERO_POINTS[i][15:0];
				if (d <= 16'd9 && !r[4]) r = {1'b1, d[3:0]};
			end
			if (!r[4]) begin
				for (int i = 0; i < 19; i++) begin
					d = cp[15:0] - ONE_POINTS[i][15:0] + 16'd1;
					if (d >= 16'd1 && d <= 16'd9 && !r[4]) r = {1'b1, d[3:0]};
				end
			end
		end
		return r;
	endfunction

endpackage

// ===== hdl/udip_if.sv =====
interface udip_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;
	modport source (output valid, data_byte, last, input ready);
	modport sink (input valid, data_byte, last, output ready);
endinterface

interface udip_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] value;
	modport source (output valid, value, input ready);
	modport sink (input valid, value, output ready);
endinterface

// ===== hdl/udip_scan.sv =====
module udip_scan
	import udip_pkg::*;
#(
	parameter int EXP_LIMIT = EXP_LIMIT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	udip_in_if.sink    in_ch,
	output logic       job_valid,
	input  logic       job_ready,
	output job_t       job
);
	localparam logic [EXP_W-1:0] LIM = EXP_W'(EXP_LIMIT);

	phase_t      phase_q;
	logic        neg_q, eneg_q;
	logic [63:0] mant_q;
	logic [EXP_W-1:0] emag_q;
	logic [20:0] part_q;
	logic [1:0]  left_q;
	// the previous codepoint, registered so the table lookup has its own cycle
	logic        cp_v_q;
	logic [20:0] cp_q;
	logic        pend_q;

	phase_t      phase_d;
	logic        neg_d, eneg_d;
	logic [63:0] mant_d;
	logic [EXP_W-1:0] emag_d;
	logic [20:0] part_d;
	logic [1:0]  left_d;
	logic        cp_v_d;
	logic [20:0] cp_d;
	logic [4:0]  dig;
	logic [63:0] mbase;
	logic [EXP_W+3:0] em;
	logic        acc;
	logic [7:0]  b;

	// an item is held back while a codepoint waits for classification
	// or while a finished text waits to hand over its job
	assign in_ch.ready = !cp_v_q && !pend_q;
	assign acc = in_ch.valid && in_ch.ready;
	assign b = in_ch.data_byte;
	assign dig = digit_of(cp_q);

	always_comb begin
		phase_d = phase_q; neg_d = neg_q; eneg_d = eneg_q; mant_d = mant_q;
		emag_d = emag_q; part_d = part_q; left_d = left_q;
		cp_v_d = 1'b0; cp_d = cp_q;
		mbase = mant_q[63] ? 64'd0 : mant_q;
		em = {4'd0, emag_q} * 11'd10 + {7'd0, dig[3:0]};
		if (cp_v_q) begin
			unique case (phase_q)
				PH_DIGITS: begin
					if (!dig[4]) begin
						phase_d = (mant_q != 64'd0 && !mant_q[63] &&
							(cp_q == CP_LOW_E || cp_q == CP_UP_E)) ? PH_EPREFIX : PH_DONE;
					end else begin
						mant_d = (mbase << 3) + (mbase << 1) + {60'd0, dig[3:0]};
					end
				end
				PH_EDIGITS: begin
					if (!dig[4]) phase_d = PH_DONE;
					else emag_d = (em > {4'd0, LIM}) ? LIM : em[EXP_W-1:0];
				end
				default: ;
			endcase
		end else if (acc && phase_q != PH_DONE) begin
			if (b == 8'd0) begin
				phase_d = PH_DONE;
				left_d = 2'd0;
			end else if (left_q != 2'd0) begin
				part_d = {part_q[14:0], b[5:0]};
				left_d = left_q - 2'd1;
				if (left_q == 2'd1) begin
					cp_v_d = 1'b1;
					cp_d = {part_q[14:0], b[5:0]};
				end
			end else begin
				if ((phase_q == PH_PREFIX || phase_q == PH_EPREFIX) && b != CH_PLUS) begin
					phase_d = (phase_q == PH_PREFIX) ? PH_DIGITS : PH_EDIGITS;
				end
				if ((phase_q == PH_PREFIX || phase_q == PH_EPREFIX) && b == CH_PLUS) begin
				end else if ((phase_q == PH_PREFIX || phase_q == PH_EPREFIX) &&
					b == CH_MINUS) begin
					if (phase_q == PH_PREFIX) neg_d = 1'b1;
					else eneg_d = 1'b1;
				end else if (!b[7]) begin
					cp_v_d = 1'b1;
					cp_d = {14'd0, b[6:0]};
				end else if (b[7:5] == 3'b110) begin
					part_d = {16'd0, b[4:0]}; left_d = 2'd1;
				end else if (b[7:4] == 4'b1110) begin
					part_d = {17'd0, b[3:0]}; left_d = 2'd2;
				end else begin
					part_d = {18'd0, b[2:0]}; left_d = 2'd3;
				end
			end
		end
	end

	// the last byte launches a job; a codepoint it completes is folded in first
	assign job_valid = pend_q && !cp_v_q;
	assign job = '{negative: neg_q, mantissa: mant_q, exp_mag: emag_q, exp_neg: eneg_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX; neg_q <= 1'b0; eneg_q <= 1'b0; mant_q <= '0;
			emag_q <= '0; part_q <= '0; left_q <= '0; cp_v_q <= 1'b0; cp_q <= '0;
			pend_q <= 1'b0;
		end else if (job_valid && job_ready) begin
			phase_q <= PH_PREFIX; neg_q <= 1'b0; eneg_q <= 1'b0; mant_q <= '0;
			emag_q <= '0; part_q <= '0; left_q <= '0; cp_v_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			phase_q <= phase_d; neg_q <= neg_d; eneg_q <= eneg_d; mant_q <= mant_d;
			emag_q <= emag_d; part_q <= part_d; left_q <= left_d;
			cp_v_q <= cp_v_d; cp_q <= cp_d;
			if (acc && in_ch.last) pend_q <= 1'b1;
		end
	end
endmodule

// ===== hdl/udip_fifo.sv =====
module udip_fifo
	import udip_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_job,
	output logic rd_valid,
	input  logic rd_ready,
	output job_t rd_job
);
	job_t       mem_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule

// ===== hdl/udip_scale.sv =====
module udip_scale
	import udip_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     job_valid,
	output logic     job_ready,
	input  job_t     job,
	udip_out_if.source out_ch
);
	logic             busy_q, neg_q, eneg_q, done_q;
	logic [63:0]      k_q;
	logic [EXP_W-1:0] cnt_q;
	logic signed [63:0] val_q;
	// divide by ten in four steps: reciprocal series, then a remainder fix-up
	logic [1:0]       sub_q;
	logic [63:0]      t_q;
	logic [63:0]      t0, t1, t2;
	logic [7:0]       q10, rem;
	logic             fin;

	assign job_ready = !busy_q && !done_q;
	assign out_ch.valid = done_q;
	assign out_ch.value = val_q;
	assign fin = sub_q == 2'd0 && (cnt_q == '0 || k_q == 64'd0 || k_q[63]);

	always_comb begin
		t0 = (k_q >> 1) + (k_q >> 2);
		t0 = t0 + (t0 >> 4);
		t1 = t_q + (t_q >> 8);
		t1 = t1 + (t1 >> 16);
		t2 = (t_q + (t_q >> 32)) >> 3;
		// the true remainder stays below twenty, so eight bits hold it
		q10 = {t_q[4:0], 3'b000} + {t_q[6:0], 1'b0};
		rem = k_q[7:0] - q10;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; done_q <= 1'b0;
		end else begin
			if (job_valid && job_ready) busy_q <= 1'b1;
			else if (busy_q && fin) begin
				busy_q <= 1'b0; done_q <= 1'b1;
			end
			if (done_q && out_ch.ready) done_q <= 1'b0;
		end
	end

	// one multiply by ten per cycle; each divide by ten steps through the reciprocal series and fix-up
	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			k_q <= job.mantissa; cnt_q <= job.exp_mag; neg_q <= job.negative;
			eneg_q <= job.exp_neg; sub_q <= 2'd0;
		end else if (busy_q) begin
			if (fin) begin
				val_q <= neg_q ? -k_q : k_q;
			end else if (eneg_q) begin
				sub_q <= sub_q + 2'd1;
				case (sub_q)
					2'd0: t_q <= t0;
					2'd1: t_q <= t1;
					2'd2: t_q <= t2;
					default: begin
						k_q <= t_q + {63'd0, rem > 8'd9};
						cnt_q <= cnt_q - EXP_W'(1);
					end
				endcase
			end else begin
				cnt_q <= cnt_q - EXP_W'(1);
				if (k_q > MUL_GUARD) begin
					k_q <= INT64_MAX; cnt_q <= '0;
				end else k_q <= (k_q << 3) + (k_q << 1);
			end
		end
	end
endmodule

// ===== hdl/unicode_decimal_integer_parser_unit.sv =====
// a byte that completes a codepoint holds the input while that codepoint is classified;
// after the last byte the job goes through the job queue to the scaler, which applies
// min(exponent, EXP_LIMIT) multiplies by ten for a positive exponent or as many divides
// by ten for a negative one; scaling stops early once the value is zero or saturated;
// the input waits after a last byte until its job is taken, and the two-entry job queue
// lets the scanner take the next text while scaling runs; arst_n clears all control state
module unicode_decimal_integer_parser_unit
	import udip_pkg::*;
#(
	parameter int EXP_LIMIT = EXP_LIMIT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	udip_in_if.sink    in_ch,
	udip_out_if.source out_ch
);
	logic sv, sr, qv, qr;
	job_t sj, qj;

	udip_scan #(.EXP_LIMIT(EXP_LIMIT)) u_scan (
		.clk, .arst_n, .in_ch, .job_valid(sv), .job_ready(sr), .job(sj)
	);
	udip_fifo u_fifo (
		.clk, .arst_n, .wr_valid(sv), .wr_ready(sr), .wr_job(sj),
		.rd_valid(qv), .rd_ready(qr), .rd_job(qj)
	);
	udip_scale u_scale (
		.clk, .arst_n, .job_valid(qv), .job_ready(qr), .job(qj), .out_ch
	);

	a_no_lost_job: assert property (@(posedge clk) disable iff (!arst_n)
		sv && !sr |=> sv) else $error("scanner job dropped");
	a_exp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sv |-> sj.exp_mag <= EXP_W'(EXP_LIMIT)) else $error("exponent beyond limit");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(out_ch.value))
		else $error("result changed while stalled");
endmodule

// ===== tb/unicode_decimal_integer_parser_unit_tb.sv =====
module unicode_decimal_integer_parser_unit_tb;
	import udip_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD = 400;
	localparam int BYTE_TARGET = 700;

	logic clk;
	logic arst_n;

	udip_in_if  in_ch ();
	udip_out_if out_ch ();

	unicode_decimal_integer_parser_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	typedef struct {
		string       text;
		int          zero_at;
		bit          typed;
		logic [63:0] value;
	} text_row_t;

	// parser state mirrored by the predictor
	phase_t      scan_phase;
	bit          scan_neg;
	bit          scan_exp_neg;
	logic [63:0] scan_mant;
	int          scan_exp_mag;
	logic [20:0] scan_cp;
	int          scan_left;

	logic [63:0] expected_values[$];
	bit          typed_pending;
	logic [63:0] typed_value;
	int          send_idle_pct;
	int          recv_stall_pct;
	bit          hold_request;
	int          quiet_cycles;
	int          bytes_sent;
	bit          failed;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int digit_value(logic [20:0] cp);
		logic [15:0] d;
		if (cp >= 21'h30 && cp <= 21'h39) return int'(cp - 21'h30);
		for (int i = 0; i < 21; i++) begin
			d = cp[15:0] - ZERO_POINTS[i][15:0];
			if (d <= 16'd9) return int'(d);
		end
		for (int i = 0; i < 19; i++) begin
			d = cp[15:0] - ONE_POINTS[i][15:0] + 16'd1;
			if (d >= 16'd1 && d <= 16'd9) return int'(d);
		end
		return -1;
	endfunction

	function automatic void clear_scan();
		scan_phase = PH_PREFIX;
		scan_neg = 1'b0;
		scan_exp_neg = 1'b0;
		scan_mant = '0;
		scan_exp_mag = 0;
		scan_cp = '0;
		scan_left = 0;
	endfunction

	function automatic void absorb_codepoint(logic [20:0] cp);
		int d;
		int m;
		d = digit_value(cp);
		if (scan_phase == PH_DIGITS) begin
			if (d < 0) begin
				if (scan_mant != 0 && !scan_mant[63] && (cp == CP_LOW_E || cp == CP_UP_E))
					scan_phase = PH_EPREFIX;
				else
					scan_phase = PH_DONE;
				return;
			end
			if (scan_mant[63]) scan_mant = '0;
			scan_mant = scan_mant * 64'd10 + 64'(d);
		end else if (scan_phase == PH_EDIGITS) begin
			if (d < 0) begin
				scan_phase = PH_DONE;
				return;
			end
			m = scan_exp_mag * 10 + d;
			scan_exp_mag = (m > EXP_LIMIT_DEF) ? EXP_LIMIT_DEF : m;
		end
	endfunction

	function automatic void absorb_lead(logic [7:0] b);
		if (!b[7]) begin
			absorb_codepoint({14'd0, b[6:0]});
		end else if (b[7:5] == 3'b110) begin
			scan_cp = {16'd0, b[4:0]};
			scan_left = 1;
		end else if (b[7:4] == 4'b1110) begin
			scan_cp = {17'd0, b[3:0]};
			scan_left = 2;
		end else begin
			scan_cp = {18'd0, b[2:0]};
			scan_left = 3;
		end
	endfunction

	function automatic logic [63:0] scaled_value();
		logic [63:0] k;
		k = scan_mant;
		if (scan_exp_mag > 0 && k != 0 && !k[63]) begin
			for (int i = 0; i < scan_exp_mag; i++) begin
				if (scan_exp_neg) begin
					k = k / 64'd10;
				end else if (k > MUL_GUARD) begin
					k = INT64_MAX;
					break;
				end else begin
					k = k * 64'd10;
				end
			end
		end
		return scan_neg ? -k : k;
	endfunction

	// returns 1 when the byte closes a text, with the parsed value
	function automatic bit parse_byte(logic [7:0] b, bit l, output logic [63:0] v);
		v = '0;
		if (scan_phase != PH_DONE) begin
			if (b == 8'd0) begin
				scan_phase = PH_DONE;
				scan_left = 0;
			end else if (scan_left > 0) begin
				scan_cp = {scan_cp[14:0], b[5:0]};
				scan_left--;
				if (scan_left == 0) absorb_codepoint(scan_cp);
			end else if (scan_phase == PH_PREFIX || scan_phase == PH_EPREFIX) begin
				if (b != CH_PLUS) begin
					if (b == CH_MINUS) begin
						if (scan_phase == PH_PREFIX) scan_neg = 1'b1;
						else scan_exp_neg = 1'b1;
						scan_phase = (scan_phase == PH_PREFIX) ? PH_DIGITS : PH_EDIGITS;
					end else begin
						scan_phase = (scan_phase == PH_PREFIX) ? PH_DIGITS : PH_EDIGITS;
						absorb_lead(b);
					end
				end
			end else begin
				absorb_lead(b);
			end
		end
		if (l) begin
			v = scaled_value();
			clear_scan();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk) begin
		logic [63:0] v;
		logic [63:0] want;
		bit          moved;
		if (arst_n) begin
			moved = 1'b0;
			if (in_ch.valid && in_ch.ready) begin
				moved = 1'b1;
				if (parse_byte(in_ch.data_byte, in_ch.last, v)) begin
					if (typed_pending) begin
						v = typed_value;
						typed_pending = 1'b0;
					end
					expected_values.push_back(v);
				end
			end
			if (out_ch.valid && out_ch.ready) begin
				moved = 1'b1;
				if (expected_values.size() == 0) begin
					$error("unexpected value %0d", out_ch.value);
					failed = 1'b1;
				end else begin
					want = expected_values.pop_front();
					if (out_ch.value !== want) begin
						$error("value mismatch: expected %0d actual %0d",
							$signed(want), out_ch.value);
						failed = 1'b1;
					end
				end
			end
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// receiver, with an occasional long hold-off
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				repeat (LONG_HOLD) begin
					out_ch.ready <= 1'b0;
					@(negedge clk);
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic put_byte(logic [7:0] b, bit l);
		if ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.last <= l;
		do @(posedge clk); while (!in_ch.ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic put_text(logic [7:0] bytes[$]);
		foreach (bytes[i]) put_byte(bytes[i], i == bytes.size() - 1);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		wait (expected_values.size() == 0);
		repeat (EXP_LIMIT_DEF + 10) @(negedge clk);
	endtask

	function automatic void push_utf8(ref logic [7:0] q[$], input logic [20:0] cp);
		if (cp < 21'h80) begin
			q.push_back(cp[7:0]);
		end else if (cp < 21'h800) begin
			q.push_back({3'b110, cp[10:6]});
			q.push_back({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			q.push_back({4'b1110, cp[15:12]});
			q.push_back({2'b10, cp[11:6]});
			q.push_back({2'b10, cp[5:0]});
		end else begin
			q.push_back({5'b11110, cp[20:18]});
			q.push_back({2'b10, cp[17:12]});
			q.push_back({2'b10, cp[11:6]});
			q.push_back({2'b10, cp[5:0]});
		end
	endfunction

	function automatic void push_digit(ref logic [7:0] q[$]);
		int d;
		d = $urandom_range(9);
		case ($urandom_range(3))
			0: push_utf8(q, ZERO_POINTS[$urandom_range(20)] + 21'(d));
			1: push_utf8(q, ONE_POINTS[$urandom_range(18)] + 21'(d == 0 ? 0 : d - 1));
			default: q.push_back(8'h30 + 8'(d));
		endcase
	endfunction

	function automatic void random_text(ref logic [7:0] q[$]);
		q.delete();
		if ($urandom_range(99) < 20) begin
			repeat ($urandom_range(8, 1)) q.push_back(8'($urandom_range(255)));
			return;
		end
		repeat ($urandom_range(2)) q.push_back(CH_PLUS);
		if ($urandom_range(2) == 0) q.push_back(CH_MINUS);
		// mostly short mantissas so that exponents have room to scale
		repeat ($urandom_range(99) < 85 ? $urandom_range(5, 1) : $urandom_range(22, 6))
			push_digit(q);
		if ($urandom_range(99) < 40) begin
			q.push_back($urandom_range(1) ? 8'h65 : 8'h45);
			if ($urandom_range(3) == 0) q.push_back(CH_PLUS);
			if ($urandom_range(1)) q.push_back(CH_MINUS);
			repeat ($urandom_range(3)) push_digit(q);
		end
		if ($urandom_range(9) == 0) q.push_back(8'($urandom_range(255)));
		if ($urandom_range(19) == 0) q.insert($urandom_range(q.size() - 1), 8'h00);
	endfunction

	text_row_t directed_rows[] = '{
		'{"0", -1, 1'b1, 64'd0},
		'{"9223372036854775807", -1, 1'b1, INT64_MAX},
		'{"-9223372036854775808", -1, 1'b0, 64'd0},
		'{"++-42", -1, 1'b1, -64'sd42},
		'{"18446744073709551616", -1, 1'b0, 64'd0},
		'{"\331\241\331\242", -1, 1'b0, 64'd0},
		'{"\342\221\240\342\221\250", -1, 1'b0, 64'd0},
		'{"\360\235\237\266\360\235\237\277", -1, 1'b0, 64'd0},
		'{"5e3", -1, 1'b1, 64'd5000},
		'{"5E-1", -1, 1'b1, 64'd0},
		'{"7e99", -1, 1'b1, INT64_MAX},
		'{"-3e2", -1, 1'b1, -64'sd300},
		'{"5e1e2", -1, 1'b0, 64'd0},
		'{"5e++-1", -1, 1'b1, 64'd0},
		'{"abc", -1, 1'b1, 64'd0},
		'{"\2003", -1, 1'b0, 64'd0},
		'{"\377\377\377\3774", -1, 1'b0, 64'd0},
		'{"1\342\221", -1, 1'b0, 64'd0},
		'{"1234", 2, 1'b1, 64'd12},
		'{"+", -1, 1'b1, 64'd0},
		'{"-", -1, 1'b1, 64'd0},
		'{"0e5", -1, 1'b1, 64'd0},
		'{"5e", -1, 1'b1, 64'd5},
		'{"19e-40", -1, 1'b1, 64'd0}
	};

	initial begin
		logic [7:0] text[$];
		int phase_no;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.last = 1'b0;
		arst_n = 1'b0;
		failed = 1'b0;
		typed_pending = 1'b0;
		hold_request = 1'b0;
		quiet_cycles = 0;
		bytes_sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		clear_scan();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[r]) begin
			text.delete();
			for (int i = 0; i < directed_rows[r].text.len(); i++) begin
				if (i == directed_rows[r].zero_at) text.push_back(8'h00);
				text.push_back(directed_rows[r].text[i]);
			end
			for (int i = 0; i < text.size(); i++) begin
				if (i == text.size() - 1 && directed_rows[r].typed) begin
					typed_value = directed_rows[r].value;
					typed_pending = 1'b1;
				end
				put_byte(text[i], i == text.size() - 1);
			end
		end
		drain();

		bytes_sent = 0;
		phase_no = 0;
		while (bytes_sent < BYTE_TARGET) begin
			if (bytes_sent >= (phase_no + 1) * BYTE_TARGET / 4) begin
				phase_no++;
				drain();
				case (phase_no)
					1: begin send_idle_pct = 50; recv_stall_pct = 0; end
					2: begin send_idle_pct = 0; recv_stall_pct = 50; hold_request = 1'b1; end
					default: begin send_idle_pct = 6; recv_stall_pct = 6; end
				endcase
			end
			random_text(text);
			put_text(text);
		end
		in_ch.valid <= 1'b0;
		wait (expected_values.size() == 0);
		repeat (EXP_LIMIT_DEF + 20) @(posedge clk);
		if (!failed)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
